// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_CLEAR      = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic read;
        logic resp;
    } dp_cmd_t;

endpackage

// ===== rtl/core/deq_ctrl.sv =====
module deq_ctrl
    import deq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = !((state_reg == S_IDLE) || (state_reg == S_RESP));
    assign accept = start && !busy;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_READ;
            S_READ:  state_next = S_RESP;
            S_RESP:  state_next = accept ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.load = accept;
    assign cmd.exec = (state_reg == S_EXEC);
    assign cmd.read = (state_reg == S_READ);
    assign cmd.resp = (state_reg == S_RESP);

endmodule

// ===== rtl/core/deq_dpath.sv =====
module deq_dpath
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    input  logic [FUNC_W-1:0]             func,
    input  logic [DATA_WIDTH-1:0]         value,
    output logic [STATUS_W-1:0]           status,
    output logic                          front_valid,
    output logic [DATA_WIDTH-1:0]         front_value,
    output logic                          back_valid,
    output logic [DATA_WIDTH-1:0]         back_value,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - AW'(1);
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [FUNC_W-1:0]     func_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [AW-1:0]         front_idx_reg, front_idx_next;
    logic [AW-1:0]         back_idx_reg,  back_idx_next;
    logic [CW-1:0]         count_reg,     count_next;
    logic [STATUS_W-1:0]   status_reg,    status_next;
    logic [DATA_WIDTH-1:0] front_rd_reg;
    logic [DATA_WIDTH-1:0] back_rd_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic                  full;
    logic                  empty;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            value_reg <= value;
        end
    end

    always_comb
    begin
        front_idx_next = front_idx_reg;
        back_idx_next  = back_idx_reg;
        count_next     = count_reg;
        status_next    = STS_OK;
        mem_we         = 1'b0;
        mem_waddr      = back_idx_reg;
        unique case (func_reg)
            FN_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = back_idx_reg;
                    back_idx_next = step_up(back_idx_reg);
                    count_next    = count_reg + CW'(1);
                end
            end
            FN_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = step_down(front_idx_reg);
                    front_idx_next = step_down(front_idx_reg);
                    count_next     = count_reg + CW'(1);
                end
            end
            FN_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = STS_EMPTY;
                end
                else
                begin
                    front_idx_next = step_up(front_idx_reg);
                    count_next     = count_reg - CW'(1);
                end
            end
            FN_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = STS_EMPTY;
                end
                else
                begin
                    back_idx_next = step_down(back_idx_reg);
                    count_next    = count_reg - CW'(1);
                end
            end
            FN_CLEAR:
            begin
                front_idx_next = '0;
                back_idx_next  = '0;
                count_next     = '0;
            end
            default:
            begin
                // Unused codes leave the queue as it is.
                status_next = STS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_idx_reg <= '0;
            back_idx_reg  <= '0;
            count_reg     <= '0;
            status_reg    <= STS_OK;
        end
        else if (cmd.exec)
        begin
            front_idx_reg <= front_idx_next;
            back_idx_reg  <= back_idx_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
        end
    end

    // The store is written during the execute cycle and read in the following cycle
    // with the updated pointers, so no bypass is needed.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[mem_waddr] <= value_reg;
        end
        if (cmd.read)
        begin
            front_rd_reg <= mem[front_idx_reg];
            back_rd_reg  <= mem[step_down(back_idx_reg)];
        end
    end

    assign status      = cmd.resp ? status_reg : STS_OK;
    assign front_valid = cmd.resp && !empty;
    assign back_valid  = cmd.resp && !empty;
    assign front_value = (cmd.resp && !empty) ? front_rd_reg : '0;
    assign back_value  = (cmd.resp && !empty) ? back_rd_reg : '0;
    assign count       = cmd.resp ? count_reg : '0;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Channel  | Direction | Handshake          | Fields
// ---------+-----------+--------------------+--------------------------------------------
// command  | in        | start, busy        | func, value
// result   | out       | done (one cycle)   | status, front_valid, front_value,
//          |           |                    | back_valid, back_value, count
//
// Each word passes through execute (pointer update and store write), store read,
// and the result cycle with done high. A new word is taken during the result cycle,
// so a word's execute can follow straight on the result cycle of the one before.
// Reset clears the pointers and the count; the element store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [FUNC_W-1:0]          func,
    input  logic [DATA_WIDTH-1:0]      value,
    output logic                       done,
    output logic [STATUS_W-1:0]        status,
    output logic                       front_valid,
    output logic [DATA_WIDTH-1:0]      front_value,
    output logic                       back_valid,
    output logic [DATA_WIDTH-1:0]      back_value,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    dp_cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    deq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .value       (value),
        .status      (status),
        .front_valid (front_valid),
        .front_value (front_value),
        .back_valid  (back_valid),
        .back_value  (back_value),
        .count       (count)
    );

    assign done = cmd.resp;

endmodule

// ===== rtl/core/deq_checker.sv =====
module deq_checker
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 8
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [STATUS_W-1:0]        status,
    input logic                       front_valid,
    input logic                       back_valid,
    input logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int CW = $clog2(DEPTH + 1);

    // Every accepted word gets its result after the execute and read states.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result did not follow an accepted word");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((front_valid == (count != '0)) && (back_valid == front_valid)))
        else $error("valid flags disagree with the count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (count <= CW'(DEPTH)))
        else $error("count exceeds the queue depth");

    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STS_EMPTY)) |-> (count == '0))
        else $error("empty error reported with a nonempty queue");

    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STS_FULL)) |-> (count == CW'(DEPTH)))
        else $error("full error reported with a queue that is not full");

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .front_valid (front_valid),
    .back_valid  (back_valid),
    .count       (count)
);

// ===== tb/sv/double_ended_queue_test.sv =====
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int DATA_W      = 8;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int RANDOM_OPS  = 725;
    localparam int CALM_FROM   = 200;
    localparam int CALM_TO     = 400;
    localparam int IDLE_PCT    = 35;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 200000;

    // Codes outside the defined operations; the block must treat them as no-ops.
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    typedef enum int {FILLING, DRAINING, MIXED} trend_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [DATA_W-1:0] data;
    } word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                fv;
        logic [DATA_W-1:0]   fval;
        logic                bv;
        logic [DATA_W-1:0]   bval;
        logic [CNT_W-1:0]    cnt;
    } outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [FUNC_W-1:0]   func = '0;
    logic [DATA_W-1:0]   value = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic                front_valid;
    logic [DATA_W-1:0]   front_value;
    logic                back_valid;
    logic [DATA_W-1:0]   back_value;
    logic [CNT_W-1:0]    count;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .value       (value),
        .done        (done),
        .status      (status),
        .front_valid (front_valid),
        .front_value (front_value),
        .back_valid  (back_valid),
        .back_value  (back_value),
        .count       (count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the deque; tail_ptr points one past the back element.
    logic [DATA_W-1:0] shadow_mem [DEPTH];
    logic [IDX_W-1:0]  head_ptr = '0;
    logic [IDX_W-1:0]  tail_ptr = '0;
    logic [CNT_W-1:0]  fill = '0;

    word_t    pending_words [$];
    outcome_t owed_results [$];
    outcome_t want;
    word_t    nxt;

    int n_words;
    int n_issued = 0;
    int n_accepted = 0;
    int mismatches = 0;
    int cycles = 0;
    int n_full_refused = 0;
    int n_empty_refused = 0;
    int n_clears = 0;
    int n_reached_full = 0;

    function automatic outcome_t apply_word(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] data);
        outcome_t r;
        r = '0;
        r.status = STS_OK;
        case (op)
            FN_PUSH_BACK, FN_PUSH_FRONT:
            begin
                if (fill == DEPTH)
                begin
                    r.status = STS_FULL;
                    n_full_refused++;
                end
                else if (op == FN_PUSH_BACK)
                begin
                    shadow_mem[tail_ptr] = data;
                    tail_ptr = tail_ptr + 1'b1;
                    fill = fill + 1'b1;
                end
                else
                begin
                    head_ptr = head_ptr - 1'b1;
                    shadow_mem[head_ptr] = data;
                    fill = fill + 1'b1;
                end
                if (fill == DEPTH && r.status == STS_OK)
                    n_reached_full++;
            end
            FN_POP_FRONT, FN_POP_BACK:
            begin
                if (fill == 0)
                begin
                    r.status = STS_EMPTY;
                    n_empty_refused++;
                end
                else
                begin
                    if (op == FN_POP_FRONT)
                        head_ptr = head_ptr + 1'b1;
                    else
                        tail_ptr = tail_ptr - 1'b1;
                    fill = fill - 1'b1;
                end
            end
            FN_CLEAR:
            begin
                head_ptr = '0;
                tail_ptr = '0;
                fill = '0;
                n_clears++;
            end
            default:
            begin
            end
        endcase
        if (fill != 0)
        begin
            r.fv = 1'b1;
            r.fval = shadow_mem[head_ptr];
            r.bv = 1'b1;
            r.bval = shadow_mem[tail_ptr - 1'b1];
        end
        r.cnt = fill;
        return r;
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    task automatic queue_word(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] data);
        word_t w;
        w.op = op;
        w.data = data;
        pending_words.push_back(w);
    endtask

    // Driver: a word is taken at an edge where start is high and busy is low.
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                owed_results.push_back(apply_word(func, value));
                n_accepted++;
            end
            if (!start || !busy)
            begin
                if (pending_words.size() != 0 &&
                    ((n_issued >= CALM_FROM && n_issued < CALM_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = pending_words.pop_front();
                    start <= 1'b1;
                    func <= nxt.op;
                    value <= nxt.data;
                    n_issued++;
                end
                else
                begin
                    start <= 1'b0;
                    func <= FUNC_W'($urandom_range(0, FN_SPARE_HI));
                    value <= DATA_W'($urandom_range(0, 255));
                end
            end
        end
    end

    // Monitor: every done cycle carries one result word.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (owed_results.size() == 0)
            begin
                $display("%0t: result word with none expected, status %0d count %0d",
                         $time, status, count);
                mismatches++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("status", int'(want.status), int'(status));
                check_field("front_valid", int'(want.fv), int'(front_valid));
                check_field("front_value", int'(want.fval), int'(front_value));
                check_field("back_valid", int'(want.bv), int'(back_valid));
                check_field("back_value", int'(want.bval), int'(back_value));
                check_field("count", int'(want.cnt), int'(count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, owed_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        trend_t             trend;
        int                 roll;
        int                 push_pct;
        logic [FUNC_W-1:0]  op;

        trend = MIXED;
        push_pct = 50;

        // Directed: pops on an empty queue, a fill to full with extreme values,
        // refused pushes, the spare codes, and a clear followed by an empty pop.
        queue_word(FN_POP_FRONT, 8'hFF);
        queue_word(FN_POP_BACK, 8'h00);
        for (int i = 0; i < DEPTH; i++)
        begin
            op = (i % 2 == 0) ? FN_PUSH_BACK : FN_PUSH_FRONT;
            if (i == 0)
                queue_word(op, 8'h00);
            else if (i == 1)
                queue_word(op, 8'hFF);
            else
                queue_word(op, DATA_W'($urandom_range(0, 255)));
        end
        queue_word(FN_PUSH_BACK, 8'hA5);
        queue_word(FN_PUSH_FRONT, 8'h5A);
        for (int c = FN_SPARE_LO; c <= FN_SPARE_HI; c++)
            queue_word(FUNC_W'(c), DATA_W'($urandom_range(0, 255)));
        queue_word(FN_CLEAR, 8'h3C);
        queue_word(FN_POP_BACK, 8'hC3);

        // Random: the mix swings between filling and draining so that the
        // queue keeps hitting both ends and the pointers wrap many times.
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 40 == 0)
            begin
                trend = trend_t'($urandom_range(0, 2));
                push_pct = (trend == FILLING) ? 75 : (trend == DRAINING) ? 25 : 50;
            end
            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = FN_CLEAR;
            else if (roll < 5)
                op = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
            else if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
            queue_word(op, DATA_W'($urandom_range(0, 255)));
        end
        n_words = pending_words.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_words || owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Ran %0d words: %0d clears, full reached %0d times.",
                 n_words, n_clears, n_reached_full);
        $display("Refused %0d pushes on a full queue and %0d pops on an empty one.",
                 n_full_refused, n_empty_refused);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
